// ===== hdl/dia_pkg.sv =====
package dia_pkg;

    // bitmap word geometry
    localparam int WORD_W  = 32;
    localparam int WORD_BW = 5;

    // request kinds
    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_CLAIM   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NONE_FREE  = 2'd1,
        STAT_IN_USE     = 2'd2,
        STAT_NOT_IN_USE = 2'd3
    } status_t;

    // control states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_BIT,
        S_DONE
    } state_t;

    // result of one word search
    typedef struct packed {
        logic               found;
        logic [WORD_BW-1:0] bit_idx;
    } find_res_t;

endpackage

// ===== hdl/device_id_allocator_core.sv =====
// claim and release: word read, S_BIT, S_DONE; an id out of range goes right to S_DONE
// allocate: S_SCAN reads bitmap words in turn, then from word 0 if the search wraps
// one request in flight at a time
// a new request is taken while the previous result waits in the output register
// after reset the bitmap ram is cleared word by word, with s_tready low
// reset sets the search pointer to 1
module device_id_allocator_core
    import dia_pkg::*;
    #(
    parameter int ID_COUNT = 256
    )
    (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] id
    input  logic [1:0] s_tuser,   // [1:0] kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] assigned_id
    output logic [1:0] m_tuser    // [1:0] status
    );

    localparam int DEPTH = (ID_COUNT + WORD_W - 1) / WORD_W;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int XW    = AW + WORD_BW;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [XW-1:0] ptr_reg, ptr_next;
    kind_t         kind_reg, kind_next;
    logic [7:0]    id_reg, id_next;
    logic          pass2_reg, pass2_next;
    logic [XW-1:0] lo_reg, lo_next;
    logic [XW-1:0] hi_reg, hi_next;
    logic          iss_act_reg, iss_act_next;
    logic [AW-1:0] iss_word_reg, iss_word_next;
    logic [AW-1:0] last_word_reg, last_word_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_word_reg, chk_word_next;
    logic          chk_last_reg, chk_last_next;
    logic [7:0]    res_id_reg, res_id_next;
    status_t       res_st_reg, res_st_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_id_reg, m_id_next;
    status_t       m_st_reg, m_st_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    find_res_t         find_res;
    logic [XW-1:0]     hit_idx;
    logic [XW-1:0]     s_id_x, id_x;
    logic              cur_bit;

    // bitmap storage
    dia_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // first free id in the word just read
    dia_word_find #(.XW(XW)) u_find (
        .data (ram_rdata),
        .word (chk_word_reg),
        .lo   (lo_reg),
        .hi   (hi_reg),
        .res  (find_res)
    );

    assign hit_idx = {chk_word_reg, find_res.bit_idx};
    assign s_id_x  = XW'(s_tdata);
    assign id_x    = XW'(id_reg);
    assign cur_bit = ram_rdata[id_reg[WORD_BW-1:0]];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_id_reg;
    assign m_tuser  = m_st_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            ptr_reg       <= XW'(1);
            iss_act_reg   <= 1'b0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            ptr_reg       <= ptr_next;
            iss_act_reg   <= iss_act_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        id_reg        <= id_next;
        pass2_reg     <= pass2_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        iss_word_reg  <= iss_word_next;
        last_word_reg <= last_word_next;
        chk_word_reg  <= chk_word_next;
        chk_last_reg  <= chk_last_next;
        res_id_reg    <= res_id_next;
        res_st_reg    <= res_st_next;
        m_id_reg      <= m_id_next;
        m_st_reg      <= m_st_next;
    end

    // sequencer: clear pass, request decode, word scan, bit update
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        ptr_next       = ptr_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        pass2_next     = pass2_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        iss_act_next   = iss_act_reg;
        iss_word_next  = iss_word_reg;
        last_word_next = last_word_reg;
        chk_valid_next = 1'b0;
        chk_word_next  = chk_word_reg;
        chk_last_next  = chk_last_reg;
        res_id_next    = res_id_reg;
        res_st_next    = res_st_reg;
        m_valid_next   = m_valid_reg;
        m_id_next      = m_id_reg;
        m_st_next      = m_st_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        // output register drains on handshake
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next = kind_t'(s_tuser);
                    id_next   = s_tdata;
                    unique case (kind_t'(s_tuser))
                        KIND_ALLOC:
                        begin
                            state_next   = S_SCAN;
                            iss_act_next = 1'b1;
                            if (ptr_reg < XW'(ID_COUNT - 1))
                            begin
                                pass2_next     = 1'b0;
                                lo_next        = ptr_reg;
                                hi_next        = XW'(ID_COUNT - 1);
                                iss_word_next  = ptr_reg[XW-1:WORD_BW];
                                last_word_next = AW'((ID_COUNT - 2) / WORD_W);
                            end
                            else
                            begin
                                pass2_next     = 1'b1;
                                lo_next        = XW'(1);
                                hi_next        = ptr_reg;
                                iss_word_next  = '0;
                                last_word_next = AW'((ID_COUNT - 2) / WORD_W);
                            end
                        end
                        KIND_CLAIM, KIND_RELEASE:
                        begin
                            if ({24'b0, s_tdata} >= 32'(ID_COUNT))
                            begin
                                res_id_next = '0;
                                res_st_next = (kind_t'(s_tuser) == KIND_CLAIM) ?
                                              STAT_IN_USE : STAT_NOT_IN_USE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = s_id_x[XW-1:WORD_BW];
                                state_next = S_BIT;
                            end
                        end
                        default:
                        begin
                            res_id_next = '0;
                            res_st_next = STAT_OK;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read issue side
                if (iss_act_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = iss_word_reg;
                    iss_word_next  = iss_word_reg + AW'(1);
                    chk_valid_next = 1'b1;
                    chk_word_next  = iss_word_reg;
                    chk_last_next  = (iss_word_reg == last_word_reg);
                    if (iss_word_reg == last_word_reg)
                    begin
                        iss_act_next = 1'b0;
                    end
                end
                // check side, in the cycle after the read is issued
                if (chk_valid_reg)
                begin
                    if (find_res.found)
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = chk_word_reg;
                        ram_wdata      = ram_rdata | (WORD_W'(1) << find_res.bit_idx);
                        ptr_next       = hit_idx + XW'(1);
                        res_id_next    = 8'(hit_idx);
                        res_st_next    = STAT_OK;
                        iss_act_next   = 1'b0;
                        chk_valid_next = 1'b0;
                        state_next     = S_DONE;
                    end
                    else if (chk_last_reg)
                    begin
                        chk_valid_next = 1'b0;
                        if (!pass2_reg && (ptr_reg > XW'(1)))
                        begin
                            // wrap: search from id 1 up to the pointer
                            pass2_next     = 1'b1;
                            lo_next        = XW'(1);
                            hi_next        = ptr_reg;
                            iss_word_next  = '0;
                            last_word_next = AW'((ptr_reg - XW'(1)) >> WORD_BW);
                            iss_act_next   = 1'b1;
                        end
                        else
                        begin
                            res_id_next  = '0;
                            res_st_next  = STAT_NONE_FREE;
                            iss_act_next = 1'b0;
                            state_next   = S_DONE;
                        end
                    end
                end
            end

            S_BIT:
            begin
                res_id_next = '0;
                ram_waddr   = id_x[XW-1:WORD_BW];
                if (kind_reg == KIND_CLAIM)
                begin
                    if (cur_bit)
                    begin
                        res_st_next = STAT_IN_USE;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        ram_wdata   = ram_rdata | (WORD_W'(1) << id_reg[WORD_BW-1:0]);
                        res_st_next = STAT_OK;
                    end
                end
                else
                begin
                    if (!cur_bit)
                    begin
                        res_st_next = STAT_NOT_IN_USE;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        ram_wdata   = ram_rdata & ~(WORD_W'(1) << id_reg[WORD_BW-1:0]);
                        res_st_next = STAT_OK;
                    end
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_id_next    = res_id_reg;
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/dia_ram.sv =====
module dia_ram
    #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
    )
    (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/dia_word_find.sv =====
module dia_word_find
    import dia_pkg::*;
    #(
    parameter int XW = 8
    )
    (
    input  logic [WORD_W-1:0]     data,
    input  logic [XW-WORD_BW-1:0] word,
    input  logic [XW-1:0]         lo,
    input  logic [XW-1:0]         hi,
    output find_res_t             res
    );

    logic [WORD_W-1:0] cand;

    // free bits whose id lies in [lo, hi)
    always_comb
    begin
        logic [XW-1:0] idx;
        idx = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            idx = {word, WORD_BW'(b)};
            cand[b] = !data[b] && (idx >= lo) && (idx < hi);
        end
    end

    // lowest candidate wins
    always_comb
    begin
        res.found   = 1'b0;
        res.bit_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                res.found   = 1'b1;
                res.bit_idx = WORD_BW'(b);
            end
        end
    end

endmodule

// ===== tb/tb_device_id_allocator_core.sv =====
module tb_device_id_allocator_core;
    import dia_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    // one expected result word
    typedef struct packed {
        logic [7:0] assigned_id;
        status_t    status;
    } grant_t;

    // shadow of the id bitmap and next-fit pointer, plus pending grants
    class id_map_scoreboard;
        logic [255:0] in_use;
        int           search_ptr;
        grant_t       grant_q[$];
        int           errors;

        function new();
            in_use     = '0;
            search_ptr = 1;
            errors     = 0;
        endfunction

        // work out the grant for an accepted request and queue it
        function void note_request(kind_t kind, logic [7:0] id);
            grant_t g;
            int     hit;
            int     i;
            g.assigned_id = '0;
            g.status      = STAT_OK;
            hit           = -1;
            case (kind)
                KIND_ALLOC:
                begin
                    // next fit: pointer up to 254, then wrap from 1
                    for (i = search_ptr; i < 255 && hit < 0; i++)
                        if (!in_use[i]) hit = i;
                    for (i = 1; i < search_ptr && hit < 0; i++)
                        if (!in_use[i]) hit = i;
                    if (hit >= 0)
                    begin
                        in_use[hit]   = 1'b1;
                        g.assigned_id = hit[7:0];
                        search_ptr    = hit + 1;
                    end
                    else
                        g.status = STAT_NONE_FREE;
                end
                KIND_CLAIM:
                begin
                    if (in_use[id]) g.status = STAT_IN_USE;
                    else in_use[id] = 1'b1;
                end
                KIND_RELEASE:
                begin
                    if (!in_use[id]) g.status = STAT_NOT_IN_USE;
                    else in_use[id] = 1'b0;
                end
                default: ;
            endcase
            grant_q.push_back(g);
        endfunction

        // compare an accepted result word with the oldest pending grant
        function void check_grant(logic [7:0] got_id, logic [1:0] got_status);
            grant_t g;
            if (grant_q.size() == 0)
            begin
                $display("%0t: result with nothing pending, id %0d status %0d",
                         $time, got_id, got_status);
                errors++;
                return;
            end
            g = grant_q.pop_front();
            if (got_id !== g.assigned_id)
            begin
                $display("%0t: assigned_id expected %0d actual %0d",
                         $time, g.assigned_id, got_id);
                errors++;
            end
            if (got_status !== g.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, g.status, got_status);
                errors++;
            end
        endfunction

        function int pending();
            return grant_q.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] id
    logic [1:0] s_tuser;   // [1:0] kind
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] assigned_id
    logic [1:0] m_tuser;   // [1:0] status

    id_map_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int stall_cycles  = 0;

    device_id_allocator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // monitor both sides at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready) sb.check_grant(m_tdata, m_tuser);
            if (s_tvalid && s_tready) sb.note_request(kind_t'(s_tuser), s_tdata);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random back-pressure, with a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one request word and wait until it is taken
    task automatic send_word(kind_t kind, logic [7:0] id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= id;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // edges of the id range, every kind, in-use and free conflicts
    task automatic run_directed();
        send_word(KIND_ALLOC, 8'h00);
        send_word(KIND_ALLOC, 8'h00);
        send_word(KIND_CLAIM, 8'h00);
        send_word(KIND_CLAIM, 8'h00);
        send_word(KIND_CLAIM, 8'hff);
        send_word(KIND_CLAIM, 8'hff);
        send_word(KIND_ALLOC, 8'hff);
        send_word(KIND_RELEASE, 8'h02);
        send_word(KIND_RELEASE, 8'h02);
        send_word(KIND_ALLOC, 8'h5a);
        send_word(KIND_RELEASE, 8'h01);
        send_word(KIND_ALLOC, 8'ha5);
        send_word(KIND_RELEASE, 8'h00);
        send_word(KIND_RELEASE, 8'hff);
        send_word(KIND_RELEASE, 8'hff);
        send_word(KIND_NONE, 8'haa);
        send_word(KIND_NONE, 8'h55);
        send_word(KIND_CLAIM, 8'hfe);
        send_word(KIND_RELEASE, 8'hfe);
        send_word(KIND_RELEASE, 8'h01);
    endtask

    // fill the map with mostly allocates, then drain it with mostly releases
    task automatic run_random(int fill_items, int drain_items);
        int    i;
        int    r;
        kind_t k;
        for (i = 0; i < fill_items + drain_items; i++)
        begin
            r = $urandom_range(99);
            if (i < fill_items)
                k = (r < 88) ? KIND_ALLOC : (r < 94) ? KIND_CLAIM :
                    (r < 98) ? KIND_RELEASE : KIND_NONE;
            else
                k = (r < 80) ? KIND_RELEASE : (r < 88) ? KIND_CLAIM :
                    (r < 95) ? KIND_ALLOC : KIND_NONE;
            send_word(k, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_ALLOC;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 10;
        recv_idle_pct = 72;
        run_directed();
        run_random(350, 200);

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 72;
        recv_idle_pct = 10;
        run_random(350, 200);

        // full rate, with a long output hold-off first
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = hold_req + 1;
        run_random(350, 200);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
